@@ src/lpcp_pkg.sv @@
// lpcp_pkg: shared types, constants and helpers for the point projection pipeline
`timescale 1ns / 1ps

package lpcp_pkg;

    // default number of fraction bits on the input coordinates
    localparam int COORD_FRAC_BITS_DEF = 16;

    // depth limit, 3 m in Q16.16
    localparam int DEPTH_LIMIT = 3 * 65536;

    // widths of the internal datapath
    localparam int CAM_W    = 51;  // camera coordinate
    localparam int ZC_W     = 18;  // in-range depth
    localparam int DIV_BITS = 31;  // quotient bits, one per divider stage
    localparam int LO_W     = 15;  // dividend bits fed into the divider stages
    localparam int PADDR_W  = 6;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ROT_X     = 3'd0,
        REG_ROT_Y     = 3'd1,
        REG_ROT_Z     = 3'd2,
        REG_TRANS     = 3'd3,
        REG_FOCAL     = 3'd4,
        REG_PRINCIPAL = 3'd5,
        REG_DIST      = 3'd6,
        REG_IMAGE     = 3'd7
    } reg_idx_t;

    // status codes
    localparam logic [1:0] ST_VISIBLE = 2'd0;
    localparam logic [1:0] ST_DEPTH   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // input word
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    // result word
    typedef struct packed {
        logic        in_view;
        logic [1:0]  status;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } result_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [47:0] rot_x;
        logic [47:0] rot_y;
        logic [47:0] rot_z;
        logic [59:0] trans;
        logic [63:0] focal;
        logic [63:0] principal;
        logic [63:0] dcoef;
        logic [31:0] image;
    } cfg_t;

    // divider stage contents, both lanes
    typedef struct packed {
        logic                rej;
        logic                sat_x;
        logic                sat_y;
        logic                neg_x;
        logic                neg_y;
        logic [ZC_W-1:0]     zc;
        logic [ZC_W-1:0]     rem_x;
        logic [ZC_W-1:0]     rem_y;
        logic [LO_W-1:0]     lo_x;
        logic [LO_W-1:0]     lo_y;
        logic [DIV_BITS-1:0] q_x;
        logic [DIV_BITS-1:0] q_y;
    } div_st_t;

    // distorted normalized coordinates
    typedef struct packed {
        logic               rej;
        logic signed [31:0] ud;
        logic signed [31:0] vd;
    } dist_out_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/lidar_point_camera_projection_top.sv @@
// lidar_point_camera_projection_top: register file and projection pipeline
// Pipeline: 3 transform, 31 divider, 8 distortion and 3 pixel stages between s_valid/s_ready
// and m_valid; the divider spends one stage per quotient bit.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset: aresetn clears all valid bits and loads the identity rotation, zeros elsewhere.
`timescale 1ns / 1ps

module lidar_point_camera_projection_top #(
    parameter int COORD_FRAC_BITS = lpcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lpcp_pkg::point_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lpcp_pkg::result_t            m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lpcp_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import lpcp_pkg::*;

    cfg_t      cfg_reg;
    logic      adv;
    logic      wr_en;
    reg_idx_t  idx;
    logic      tr_valid, dv_valid, ds_valid;
    div_st_t   tr_data, dv_data;
    dist_out_t ds_data;

    assign pready = 1'b1;
    assign adv    = !m_valid || m_ready;
    assign s_ready = adv;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_x     <= 48'd16384;
            cfg_reg.rot_y     <= 48'd16384 << 16;
            cfg_reg.rot_z     <= 48'd16384 << 32;
            cfg_reg.trans     <= '0;
            cfg_reg.focal     <= '0;
            cfg_reg.principal <= '0;
            cfg_reg.dcoef     <= '0;
            cfg_reg.image     <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_ROT_X:     cfg_reg.rot_x     <= pwdata[47:0];
                REG_ROT_Y:     cfg_reg.rot_y     <= pwdata[47:0];
                REG_ROT_Z:     cfg_reg.rot_z     <= pwdata[47:0];
                REG_TRANS:     cfg_reg.trans     <= pwdata[59:0];
                REG_FOCAL:     cfg_reg.focal     <= pwdata;
                REG_PRINCIPAL: cfg_reg.principal <= pwdata;
                REG_DIST:      cfg_reg.dcoef     <= pwdata;
                default:       cfg_reg.image     <= pwdata[31:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        case (idx)
            REG_ROT_X:     prdata = 64'(cfg_reg.rot_x);
            REG_ROT_Y:     prdata = 64'(cfg_reg.rot_y);
            REG_ROT_Z:     prdata = 64'(cfg_reg.rot_z);
            REG_TRANS:     prdata = 64'(cfg_reg.trans);
            REG_FOCAL:     prdata = cfg_reg.focal;
            REG_PRINCIPAL: prdata = cfg_reg.principal;
            REG_DIST:      prdata = cfg_reg.dcoef;
            default:       prdata = 64'(cfg_reg.image);
        endcase
    end

    lpcp_transform #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cfg       (cfg_reg),
        .out_valid (tr_valid),
        .out_data  (tr_data)
    );

    lpcp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (tr_valid),
        .in_data   (tr_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    lpcp_distort u_distort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dv_valid),
        .in_data   (dv_data),
        .cfg       (cfg_reg),
        .out_valid (ds_valid),
        .out_data  (ds_data)
    );

    lpcp_pixel u_pixel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (ds_valid),
        .in_data   (ds_data),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // a visible word always reports the visible status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.in_view |-> m_data.status == ST_VISIBLE)
        else $error("in_view set without visible status");

    // rejected or outside words carry zero pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.in_view |->
            m_data.pixel_x == 16'd0 && m_data.pixel_y == 16'd0 &&
            (m_data.status == ST_DEPTH || m_data.status == ST_OUTSIDE))
        else $error("hidden point with pixel data or bad status");

    // a depth reject leaving the divider is captured in the first distortion reject flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dv_valid && dv_data.rej |=> u_distort.rej_reg[0])
        else $error("reject flag lost entering distortion");

endmodule

@@ src/lpcp_transform.sv @@
// lpcp_transform: rotation, translation, depth check and divider setup
`timescale 1ns / 1ps

module lpcp_transform #(
    parameter int COORD_FRAC_BITS = lpcp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  lpcp_pkg::point_t  in_data,
    input  lpcp_pkg::cfg_t    cfg,
    output logic              out_valid,
    output lpcp_pkg::div_st_t out_data
);
    import lpcp_pkg::*;

    localparam int SHIFT = COORD_FRAC_BITS - 2;

    logic [2:0]              vld_reg;
    logic signed [47:0]      prod_reg [3][3];
    logic signed [CAM_W-1:0] cam_reg [3];
    div_st_t                 div_reg;

    logic signed [31:0]      pt [3];
    logic [47:0]             rows [3];
    logic signed [47:0]      prod_next [3][3];
    logic signed [CAM_W-1:0] cam_next [3];
    logic signed [49:0]      sum_w;
    logic signed [49:0]      shr_w;
    logic [CAM_W-1:0]        mag_x;
    logic [CAM_W-1:0]        mag_y;
    logic [CAM_W-1:0]        lim_w;
    div_st_t                 div_next;

    assign pt[0]   = in_data.point_x;
    assign pt[1]   = in_data.point_y;
    assign pt[2]   = in_data.point_z;
    assign rows[0] = cfg.rot_x;
    assign rows[1] = cfg.rot_y;
    assign rows[2] = cfg.rot_z;

    // rotation products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = 48'($signed(rows[i][16*j +: 16])) * 48'(pt[j]);
            end
        end
    end

    // row sums, scaling and translation
    always_comb begin
        sum_w = '0;
        shr_w = '0;
        for (int i = 0; i < 3; i++) begin
            sum_w = 50'(prod_reg[i][0]) + 50'(prod_reg[i][1]) + 50'(prod_reg[i][2]);
            shr_w = sum_w >>> SHIFT;
            cam_next[i] = CAM_W'(shr_w) + CAM_W'($signed(cfg.trans[20*i +: 20]));
        end
    end

    // depth check, magnitudes and divider seed
    always_comb begin
        mag_x = cam_reg[0][CAM_W-1] ? CAM_W'(-cam_reg[0]) : CAM_W'(cam_reg[0]);
        mag_y = cam_reg[1][CAM_W-1] ? CAM_W'(-cam_reg[1]) : CAM_W'(cam_reg[1]);
        lim_w = CAM_W'({cam_reg[2][ZC_W-1:0], {LO_W{1'b0}}});
        div_next.rej   = (cam_reg[2] <= CAM_W'(0)) || (cam_reg[2] > CAM_W'(DEPTH_LIMIT));
        div_next.sat_x = mag_x >= lim_w;
        div_next.sat_y = mag_y >= lim_w;
        div_next.neg_x = cam_reg[0][CAM_W-1];
        div_next.neg_y = cam_reg[1][CAM_W-1];
        div_next.zc    = cam_reg[2][ZC_W-1:0];
        div_next.rem_x = mag_x[LO_W +: ZC_W];
        div_next.rem_y = mag_y[LO_W +: ZC_W];
        div_next.lo_x  = mag_x[LO_W-1:0];
        div_next.lo_y  = mag_y[LO_W-1:0];
        div_next.q_x   = '0;
        div_next.q_y   = '0;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            cam_reg  <= cam_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = div_reg;

endmodule

@@ src/lpcp_divider.sv @@
// lpcp_divider: pipelined restoring divider, one quotient bit per stage, two lanes
`timescale 1ns / 1ps

module lpcp_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  lpcp_pkg::div_st_t in_data,
    output logic              out_valid,
    output lpcp_pkg::div_st_t out_data
);
    import lpcp_pkg::*;

    logic [DIV_BITS-1:0] vld_reg;
    div_st_t             st_reg  [DIV_BITS];
    div_st_t             prev_w  [DIV_BITS];
    div_st_t             st_next [DIV_BITS];

    // one restoring step: shift in a bit, subtract when it fits
    function automatic logic [ZC_W:0] div_step(input logic [ZC_W-1:0] rem,
                                               input logic nb,
                                               input logic [ZC_W-1:0] den);
        logic [ZC_W:0] t;
        logic [ZC_W:0] d;
        logic          ge;
        t  = {rem, nb};
        ge = t >= {1'b0, den};
        d  = t - {1'b0, den};
        return ge ? {1'b1, d[ZC_W-1:0]} : {1'b0, t[ZC_W-1:0]};
    endfunction

    genvar k;
    generate
        for (k = 0; k < DIV_BITS; k++) begin : g_stage
            localparam int J = DIV_BITS - 1 - k;
            logic          nb_x;
            logic          nb_y;
            logic [ZC_W:0] sx;
            logic [ZC_W:0] sy;

            if (k == 0) begin : g_first
                assign prev_w[k] = in_data;
            end else begin : g_rest
                assign prev_w[k] = st_reg[k-1];
            end

            // dividend bit entering at this stage
            if (J >= 16) begin : g_bit
                assign nb_x = prev_w[k].lo_x[J-16];
                assign nb_y = prev_w[k].lo_y[J-16];
            end else begin : g_zero
                assign nb_x = 1'b0;
                assign nb_y = 1'b0;
            end

            assign sx = div_step(prev_w[k].rem_x, nb_x, prev_w[k].zc);
            assign sy = div_step(prev_w[k].rem_y, nb_y, prev_w[k].zc);

            always_comb begin
                st_next[k]       = prev_w[k];
                st_next[k].rem_x = sx[ZC_W-1:0];
                st_next[k].rem_y = sy[ZC_W-1:0];
                st_next[k].q_x   = {prev_w[k].q_x[DIV_BITS-2:0], sx[ZC_W]};
                st_next[k].q_y   = {prev_w[k].q_y[DIV_BITS-2:0], sy[ZC_W]};
            end

            // stage register
            always_ff @(posedge aclk) begin
                if (adv) begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DIV_BITS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_BITS-1];
    assign out_data  = st_reg[DIV_BITS-1];

endmodule

@@ src/lpcp_distort.sv @@
// lpcp_distort: radial and tangential lens distortion on the normalized point
`timescale 1ns / 1ps

module lpcp_distort (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  lpcp_pkg::div_st_t   in_data,
    input  lpcp_pkg::cfg_t      cfg,
    output logic                out_valid,
    output lpcp_pkg::dist_out_t out_data
);
    import lpcp_pkg::*;

    logic [7:0] vld_reg;
    logic [7:0] rej_reg;

    logic signed [31:0] u0_reg, v0_reg;
    logic signed [31:0] u1_reg, v1_reg, uu1_reg, vv1_reg, uv1_reg;
    logic signed [31:0] u2_reg, v2_reg, uu2_reg, vv2_reg, uv2_reg, r2_reg;
    logic signed [31:0] u3_reg, v3_reg, r4_reg;
    logic signed [33:0] k1r2_3_reg;
    logic signed [35:0] du1_reg, du2_reg, dv1_reg, dv2_reg;
    logic signed [31:0] u4_reg, v4_reg, du4_reg, dv4_reg;
    logic signed [33:0] k1r2_4_reg, k2r4_reg;
    logic signed [31:0] u5_reg, v5_reg, du5_reg, dv5_reg, lf_reg;
    logic signed [31:0] du6_reg, dv6_reg;
    logic signed [47:0] pu_reg, pv_reg;
    logic signed [31:0] ud_reg, vd_reg;

    logic signed [15:0] k1, k2, p1, p2;
    logic signed [31:0] q_x, q_y;
    logic signed [31:0] u_next, v_next;
    logic signed [33:0] su, sv;

    assign k1 = $signed(cfg.dcoef[15:0]);
    assign k2 = $signed(cfg.dcoef[31:16]);
    assign p1 = $signed(cfg.dcoef[47:32]);
    assign p2 = $signed(cfg.dcoef[63:48]);

    // signed quotient with saturation
    always_comb begin
        q_x = 32'({1'b0, in_data.q_x});
        q_y = 32'({1'b0, in_data.q_y});
        if (in_data.sat_x) begin
            q_x = 32'sh7FFFFFFF;
        end
        if (in_data.sat_y) begin
            q_y = 32'sh7FFFFFFF;
        end
        u_next = in_data.neg_x ? -q_x : q_x;
        v_next = in_data.neg_y ? -q_y : q_y;
    end

    assign su = 34'(r2_reg) + (34'(uu2_reg) <<< 1);
    assign sv = 34'(r2_reg) + (34'(vv2_reg) <<< 1);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // distortion stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            rej_reg <= {rej_reg[6:0], in_data.rej};
            // normalized coordinates
            u0_reg <= u_next;
            v0_reg <= v_next;
            // squares and cross term
            u1_reg  <= u0_reg;
            v1_reg  <= v0_reg;
            uu1_reg <= sat32((64'(u0_reg) * 64'(u0_reg)) >>> 16);
            vv1_reg <= sat32((64'(v0_reg) * 64'(v0_reg)) >>> 16);
            uv1_reg <= sat32((64'(u0_reg) * 64'(v0_reg)) >>> 16);
            // squared radius
            u2_reg  <= u1_reg;
            v2_reg  <= v1_reg;
            uu2_reg <= uu1_reg;
            vv2_reg <= vv1_reg;
            uv2_reg <= uv1_reg;
            r2_reg  <= sat32(64'(33'(uu1_reg) + 33'(vv1_reg)));
            // fourth power, first radial term and tangential terms
            u3_reg     <= u2_reg;
            v3_reg     <= v2_reg;
            r4_reg     <= sat32((64'(r2_reg) * 64'(r2_reg)) >>> 16);
            k1r2_3_reg <= 34'((48'(k1) * 48'(r2_reg)) >>> 14);
            du1_reg    <= 36'((49'(p1) * 49'(uv2_reg) * 49'sd2) >>> 14);
            du2_reg    <= 36'((50'(p2) * 50'(su)) >>> 14);
            dv1_reg    <= 36'((50'(p1) * 50'(sv)) >>> 14);
            dv2_reg    <= 36'((49'(p2) * 49'(uv2_reg) * 49'sd2) >>> 14);
            // radial second term and tangential sums
            u4_reg     <= u3_reg;
            v4_reg     <= v3_reg;
            k1r2_4_reg <= k1r2_3_reg;
            k2r4_reg   <= 34'((48'(k2) * 48'(r4_reg)) >>> 14);
            du4_reg    <= sat32(64'(37'(du1_reg) + 37'(du2_reg)));
            dv4_reg    <= sat32(64'(37'(dv1_reg) + 37'(dv2_reg)));
            // radial factor
            u5_reg  <= u4_reg;
            v5_reg  <= v4_reg;
            du5_reg <= du4_reg;
            dv5_reg <= dv4_reg;
            lf_reg  <= sat32(64'(36'sd65536 + 36'(k1r2_4_reg) + 36'(k2r4_reg)));
            // radial scaling
            du6_reg <= du5_reg;
            dv6_reg <= dv5_reg;
            pu_reg  <= 48'((64'(lf_reg) * 64'(u5_reg)) >>> 16);
            pv_reg  <= 48'((64'(lf_reg) * 64'(v5_reg)) >>> 16);
            // distorted coordinates
            ud_reg <= sat32(64'(49'(pu_reg) + 49'(du6_reg)));
            vd_reg <= sat32(64'(49'(pv_reg) + 49'(dv6_reg)));
        end
    end

    assign out_valid    = vld_reg[7];
    assign out_data.rej = rej_reg[7];
    assign out_data.ud  = ud_reg;
    assign out_data.vd  = vd_reg;

endmodule

@@ src/lpcp_pixel.sv @@
// lpcp_pixel: focal scaling, principal point offset, image bounds and result register
`timescale 1ns / 1ps

module lpcp_pixel (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  lpcp_pkg::dist_out_t in_data,
    input  lpcp_pkg::cfg_t      cfg,
    output logic                out_valid,
    output lpcp_pkg::result_t   out_data
);
    import lpcp_pkg::*;

    logic [2:0]         vld_reg;
    logic [1:0]         rej_reg;
    logic signed [48:0] fxu_reg, fyv_reg;
    logic signed [49:0] px_reg, py_reg;
    result_t            res_reg;

    logic signed [49:0] w_lim, h_lim;
    logic               in_img;
    result_t            res_next;

    assign w_lim = $signed({18'b0, cfg.image[15:0], 16'b0});
    assign h_lim = $signed({18'b0, cfg.image[31:16], 16'b0});

    // bounds check and result forming
    always_comb begin
        in_img = (px_reg > 50'sd0) && (px_reg < w_lim) &&
                 (py_reg > 50'sd0) && (py_reg < h_lim);
        res_next = '0;
        if (rej_reg[1]) begin
            res_next.status = ST_DEPTH;
        end else if (in_img) begin
            res_next.in_view = 1'b1;
            res_next.status  = ST_VISIBLE;
            res_next.pixel_x = px_reg[31:16];
            res_next.pixel_y = py_reg[31:16];
        end else begin
            res_next.status = ST_OUTSIDE;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // focal products, offsets, result register
    always_ff @(posedge aclk) begin
        if (adv) begin
            rej_reg <= {rej_reg[0], in_data.rej};
            fxu_reg <= 49'((65'($signed({1'b0, cfg.focal[31:0]})) * 65'(in_data.ud)) >>> 16);
            fyv_reg <= 49'((65'($signed({1'b0, cfg.focal[63:32]})) * 65'(in_data.vd)) >>> 16);
            px_reg  <= 50'(fxu_reg) + $signed({18'b0, cfg.principal[31:0]});
            py_reg  <= 50'(fyv_reg) + $signed({18'b0, cfg.principal[63:32]});
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = res_reg;

endmodule
